### hw/rtl/gwmp_pkg.sv
// Shared types, field widths, register codes and reset values for the gated
// window mean proximity unit. Depends on nothing; the controller, datapath and top level import it.
`default_nettype none

package gwmp_pkg;

    // Field widths of the stream and configuration beats
    localparam int SENSOR_W   = 4;
    localparam int SAMPLE_W   = 9;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    localparam int SAMPLE_MAX = 511;

    // Parameter defaults
    localparam int SENSOR_COUNT_DEF = 5;
    localparam int WINDOW_LEN_DEF   = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VALID_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 2'd2;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] VALID_LIMIT_RST = 9'd300;
    localparam logic [SAMPLE_W-1:0] CLOSE_THR_RST   = 9'd150;
    localparam logic [COUNT_W-1:0]  MIN_COUNT_RST   = 6'd3;

    // Width of a window sum
    function automatic int sum_width(input int wl);
        return $clog2(wl * SAMPLE_MAX + 1);
    endfunction

    // Window store depth: one row of 2**clog2(wl) slots per sensor
    function automatic int win_depth(input int sc, input int wl);
        return sc << $clog2(wl);
    endfunction

    // Step counter width: covers the clear sweep and the divider steps
    function automatic int ctr_width(input int sc, input int wl);
        int d;
        int s;
        d = win_depth(sc, wl);
        s = sum_width(wl);
        return $clog2(((d > s) ? d : s) + 1);
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;    // write zero at the sweep address
        logic load;      // capture the input beat, clear the accumulators
        logic win_wr;    // write the sample into the window, advance its pointer
        logic rd;        // read window slot at the step index
        logic div_init;  // load the divider from the accumulators
        logic div_step;  // one restoring division step
        logic out_load;  // capture the result beat
    } gwmp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sensor_ok; // captured sensor number is in range
    } gwmp_status_t;

endpackage

`default_nettype wire

### hw/rtl/gwmp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gwmp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/gwmp_ctrl.sv
// Sequencer for the gated window mean unit: clear sweep, window write, window
// walk, serial division and result hand-off. Depends on gwmp_pkg.
`default_nettype none

module gwmp_ctrl #(
    parameter int SENSOR_COUNT = 5,
    parameter int WINDOW_LEN   = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  gwmp_pkg::gwmp_status_t  status,
    output gwmp_pkg::gwmp_cmd_t     cmd,
    output logic [gwmp_pkg::ctr_width(SENSOR_COUNT, WINDOW_LEN)-1:0] idx
);

    import gwmp_pkg::*;

    localparam int CTR_W = ctr_width(SENSOR_COUNT, WINDOW_LEN);
    localparam int DEPTH = win_depth(SENSOR_COUNT, WINDOW_LEN);
    localparam int SUM_W = sum_width(WINDOW_LEN);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    state_t           state_reg, state_next;
    logic [CTR_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == CTR_W'(DEPTH - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                idx_next = '0;
                if (status.sensor_ok) begin
                    cmd.win_wr = 1'b1;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_READ: begin
                cmd.rd   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CTR_W'(WINDOW_LEN - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                idx_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == CTR_W'(SUM_W - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign idx      = idx_reg;

    // A result beat only appears after the hold state hands it off
    a_valid_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result valid rose outside the hand-off");

    // The window walk only runs for a sensor that has a window
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> status.sensor_ok)
        else $error("window walk for an out-of-range sensor");

    // Hold the finished result while the output register is still full
    a_hold_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && !out_free) |=> (state_reg == ST_HOLD))
        else $error("hand-off left while the output register was full");

endmodule

`default_nettype wire

### hw/rtl/gwmp_dp.sv
// Datapath of the gated window mean unit: config registers, write pointers,
// window store, gated accumulator, restoring divider and result register.
// Depends on gwmp_pkg and gwmp_ram.
`default_nettype none

module gwmp_dp #(
    parameter int SENSOR_COUNT = 5,
    parameter int WINDOW_LEN   = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [gwmp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gwmp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [gwmp_pkg::SENSOR_W-1:0]         in_sensor,
    input  logic [gwmp_pkg::SAMPLE_W-1:0]         in_sample,
    input  gwmp_pkg::gwmp_cmd_t                   cmd,
    input  logic [gwmp_pkg::ctr_width(SENSOR_COUNT, WINDOW_LEN)-1:0] idx,
    output gwmp_pkg::gwmp_status_t                status,
    output logic [gwmp_pkg::SENSOR_W-1:0]         out_sensor,
    output logic [gwmp_pkg::SAMPLE_W-1:0]         out_mean,
    output logic [gwmp_pkg::COUNT_W-1:0]          out_count,
    output logic                                  out_close
);

    import gwmp_pkg::*;

    localparam int DEPTH  = win_depth(SENSOR_COUNT, WINDOW_LEN);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int JW     = $clog2(WINDOW_LEN);
    localparam int SUM_W  = sum_width(WINDOW_LEN);
    localparam int FULL_W = SENSOR_W + JW;

    // Configuration registers
    logic [SAMPLE_W-1:0] valid_limit_reg;
    logic [SAMPLE_W-1:0] close_thr_reg;
    logic [COUNT_W-1:0]  min_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_limit_reg <= VALID_LIMIT_RST;
            close_thr_reg   <= CLOSE_THR_RST;
            min_count_reg   <= MIN_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VALID_LIMIT: valid_limit_reg <= cfg_data;
                REG_CLOSE_THR:   close_thr_reg   <= cfg_data;
                REG_MIN_COUNT:   min_count_reg   <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured input beat
    logic [SENSOR_W-1:0] sensor_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sensor_reg <= in_sensor;
            sample_reg <= in_sample;
        end
    end

    assign status.sensor_ok = ({1'b0, sensor_reg} < (SENSOR_W + 1)'(SENSOR_COUNT));

    // Per-sensor write pointers, selected by compare
    logic [JW-1:0] wp_reg [SENSOR_COUNT];
    logic [JW-1:0] wp_cur;

    always_comb begin
        wp_cur = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (sensor_reg == SENSOR_W'(i)) begin
                wp_cur = wp_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                wp_reg[i] <= '0;
            end
        end else if (cmd.win_wr) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (sensor_reg == SENSOR_W'(i)) begin
                    wp_reg[i] <= (wp_cur == JW'(WINDOW_LEN - 1)) ? '0 : wp_cur + 1'b1;
                end
            end
        end
    end

    // Window store: row per sensor, slot in the low bits
    logic [FULL_W-1:0]   wr_full;
    logic [FULL_W-1:0]   rd_full;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic [SAMPLE_W-1:0] rd_data;

    assign wr_full = {sensor_reg, wp_cur};
    assign rd_full = {sensor_reg, idx[JW-1:0]};
    assign wr_addr = cmd.clr_wr ? idx[ADDR_W-1:0] : wr_full[ADDR_W-1:0];
    assign wr_data = cmd.clr_wr ? '0 : sample_reg;

    gwmp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (cmd.clr_wr | cmd.win_wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (rd_full[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Gated accumulation, one slot per cycle behind the read
    logic               rd_pend_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               gate_pass;

    assign gate_pass = (rd_data != '0) && (rd_data < valid_limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (rd_pend_reg && gate_pass) begin
            sum_reg   <= sum_reg + SUM_W'(rd_data);
            count_reg <= count_reg + 1'b1;
        end
    end

    // Restoring divider, one quotient bit per step
    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W:0]   rem_shift;
    logic [COUNT_W:0]   rem_diff;
    logic               rem_ge;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count_reg});
    assign rem_diff  = rem_shift - {1'b0, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
        end
    end

    // Result register
    logic                qualify;
    logic [SAMPLE_W-1:0] mean_cur;
    logic [SENSOR_W-1:0] out_sensor_reg;
    logic [SAMPLE_W-1:0] out_mean_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_close_reg;

    assign qualify  = status.sensor_ok && (count_reg > min_count_reg);
    assign mean_cur = qualify ? quo_reg[SAMPLE_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sensor_reg <= sensor_reg;
            out_mean_reg   <= mean_cur;
            out_count_reg  <= status.sensor_ok ? count_reg : '0;
            out_close_reg  <= (mean_cur != '0) && (mean_cur < close_thr_reg);
        end
    end

    assign out_sensor = out_sensor_reg;
    assign out_mean   = out_mean_reg;
    assign out_count  = out_count_reg;
    assign out_close  = out_close_reg;

    // A qualified quotient always fits the mean field
    a_mean_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && qualify) |-> (quo_reg[SUM_W-1:SAMPLE_W] == '0))
        else $error("quotient wider than the mean field");

    // A nonzero mean needs more gated samples than the minimum
    a_mean_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (out_mean_reg == '0 || out_count_reg > min_count_reg))
        else $error("mean reported with too few samples");

    // Close flag never rides on a zero mean
    a_close_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (!out_close_reg || out_mean_reg != '0))
        else $error("close flag with zero mean");

endmodule

`default_nettype wire

### hw/rtl/gated_window_mean_proximity_unit.sv
// Top level of the gated window mean proximity unit: stream ports, config port,
// controller and datapath. Depends on gwmp_pkg, gwmp_ctrl, gwmp_dp, gwmp_ram.
//
//  Channel   Direction  Handshake                Payload
//  s_        in         s_tvalid / s_tready      sensor_id, sample_cm
//  m_        out        m_tvalid / m_tready      result_sensor, mean_cm, valid_count, is_close
//  cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  An in-range beat passes from accept to result through the window write, then
//  one window slot read per cycle from the single-read-port window RAM, then one
//  quotient bit per cycle from the restoring divider, then the result hand-off.
//  An out-of-range sensor beat skips the window walk and the divider and returns a zero
//  mean, count and close flag. After reset the window RAM is swept to zero, one slot a
//  cycle, over all SENSOR_COUNT << clog2(WINDOW_LEN) slots (40 at the defaults); s_tready stays low.
//  A waiting result does not block the next beat; a finished result holds in the
//  hand-off state only while the output register is still full.
`default_nettype none

module gated_window_mean_proximity_unit #(
    parameter int SENSOR_COUNT = gwmp_pkg::SENSOR_COUNT_DEF,
    parameter int WINDOW_LEN   = gwmp_pkg::WINDOW_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gwmp_pkg::S_TDATA_W-1:0]    s_tdata,   // [3:0] sensor_id, [12:4] sample_cm
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gwmp_pkg::M_TDATA_W-1:0]    m_tdata,   // [3:0] result_sensor, [12:4] mean_cm,
                                                         // [18:13] valid_count, [19] is_close
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gwmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gwmp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import gwmp_pkg::*;

    localparam int CTR_W = ctr_width(SENSOR_COUNT, WINDOW_LEN);

    gwmp_cmd_t           cmd;
    gwmp_status_t        status;
    logic [CTR_W-1:0]    idx;
    logic [SENSOR_W-1:0] out_sensor;
    logic [SAMPLE_W-1:0] out_mean;
    logic [COUNT_W-1:0]  out_count;
    logic                out_close;

    // Config writes are always accepted and take effect in the next cycle
    assign cfg_ready = 1'b1;

    // Sequencer: owns the stream handshakes and the step counter
    gwmp_ctrl #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .WINDOW_LEN   (WINDOW_LEN)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .idx      (idx)
    );

    // Datapath: window store, gated sum, divider, result register
    gwmp_dp #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .WINDOW_LEN   (WINDOW_LEN)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_sensor  (s_tdata[SENSOR_W-1:0]),
        .in_sample  (s_tdata[SENSOR_W+SAMPLE_W-1:SENSOR_W]),
        .cmd        (cmd),
        .idx        (idx),
        .status     (status),
        .out_sensor (out_sensor),
        .out_mean   (out_mean),
        .out_count  (out_count),
        .out_close  (out_close)
    );

    // Pack the result beat, pad to whole bytes
    assign m_tdata = {
        (M_TDATA_W - SENSOR_W - SAMPLE_W - COUNT_W - 1)'(0),
        out_close,
        out_count,
        out_mean,
        out_sensor
    };

endmodule

`default_nettype wire

### sim/gated_window_mean_proximity_unit_test.sv
// Self-checking bench for gated_window_mean_proximity_unit: per-sensor sample rings,
// gated mean and close flag predicted in a scoreboard class, stream handshakes driven.
// Depends on gwmp_pkg and the RTL of the unit; needs no files or arguments.
module gated_window_mean_proximity_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gwmp_pkg::*;

    localparam int SENSORS = SENSOR_COUNT_DEF;
    localparam int WIN     = WINDOW_LEN_DEF;

    // Index that maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_BEATS = 1800;
    localparam int PHASES       = 6;
    // Sender and receiver both run without idling across this span of beats
    localparam int QUIET_LO     = 900;
    localparam int QUIET_HI     = 1200;
    // Long receiver hold-off, started once this many results have come back
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 600;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Result beat as laid out in m_tdata, lowest field last
    typedef struct packed {
        logic                near;
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] mean;
        logic [SENSOR_W-1:0] sensor;
    } mean_result_t;

    // Tracks the sample rings and registers, queues the expected mean per beat
    class window_mean_board;
        logic [SAMPLE_W-1:0] valid_limit;
        logic [SAMPLE_W-1:0] close_thr;
        logic [COUNT_W-1:0]  min_count;
        logic [SAMPLE_W-1:0] ring [SENSORS][WIN];
        int unsigned         next_slot [SENSORS];
        mean_result_t        pending [$];
        int                  errors;
        int                  samples;
        int                  results;
        int                  stray_sensor;
        int                  near_seen;
        int                  means_seen;

        function new();
            valid_limit = VALID_LIMIT_RST;
            close_thr   = CLOSE_THR_RST;
            min_count   = MIN_COUNT_RST;
            foreach (ring[s, k]) ring[s][k] = '0;
            foreach (next_slot[s]) next_slot[s] = 0;
            errors = 0;
            samples = 0;
            results = 0;
            stray_sensor = 0;
            near_seen = 0;
            means_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_VALID_LIMIT: valid_limit = data;
                REG_CLOSE_THR:   close_thr = data;
                REG_MIN_COUNT:   min_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Push an in-range sample into its sensor's ring; queue the expected result for every beat
        function void note_sample(logic [SENSOR_W-1:0] sensor, logic [SAMPLE_W-1:0] sample);
            mean_result_t r;
            int sum;
            int cnt;
            r = '0;
            r.sensor = sensor;
            sum = 0;
            cnt = 0;
            samples++;
            if (sensor < SENSORS) begin
                ring[sensor][next_slot[sensor]] = sample;
                next_slot[sensor] = (next_slot[sensor] + 1) % WIN;
                for (int k = 0; k < WIN; k++) begin
                    if (ring[sensor][k] != 0 && ring[sensor][k] < valid_limit) begin
                        sum += ring[sensor][k];
                        cnt++;
                    end
                end
                if (cnt > min_count)
                    r.mean = SAMPLE_W'(sum / cnt);
                r.count = COUNT_W'(cnt);
                r.near = (r.mean != 0) && (r.mean < close_thr);
            end else begin
                stray_sensor++;
            end
            if (r.mean != 0) means_seen++;
            if (r.near) near_seen++;
            pending.push_back(r);
        endfunction

        function void field_check(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            mean_result_t got;
            mean_result_t want;
            got = beat[$bits(mean_result_t)-1:0];
            results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%t unexpected result beat: expected none, got %h", $time, beat);
                return;
            end
            want = pending.pop_front();
            field_check("result_sensor", want.sensor, got.sensor);
            field_check("mean_cm", want.mean, got.mean);
            field_check("valid_count", want.count, got.count);
            field_check("is_close", want.near, got.near);
        endfunction
    endclass

    window_mean_board board = new();

    gated_window_mean_proximity_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Offer one sample beat, optionally after an idle gap; leave tvalid high afterward
    // so back-to-back beats never lower and raise it within one step.
    task automatic send_sample(input logic [SENSOR_W-1:0] sensor,
                               input logic [SAMPLE_W-1:0] sample);
        int gap;
        gap = 0;
        if (!(board.samples >= QUIET_LO && board.samples < QUIET_HI) &&
            $urandom_range(99) < 29)
            gap = $urandom_range(30, 1);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'({sample, sensor});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(sensor, sample);
    endtask

    // Stop offering and wait until every queued result has been returned
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    // Hold cfg_valid high across consecutive writes; callers lower it once
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic configure(input logic [SAMPLE_W-1:0] limit,
                             input logic [SAMPLE_W-1:0] thr,
                             input logic [COUNT_W-1:0]  minc);
        drain();
        write_reg(REG_VALID_LIMIT, limit);
        write_reg(REG_CLOSE_THR, thr);
        write_reg(REG_MIN_COUNT, CFG_DATA_W'(minc));
        cfg_valid <= 1'b0;
    endtask

    // Mostly gate-passing samples, with zeros and full-range values mixed in
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] limit);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30 || limit < 2)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX));
        if (r < 35)
            return SAMPLE_W'(limit - 1);
        return SAMPLE_W'($urandom_range(limit - 1, 1));
    endfunction

    // Result sink: random stalls, one long hold-off, a quiet stretch
    initial begin : result_sink
        int  stall_left;
        bit  held_once;
        stall_left = 0;
        held_once  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            // Hold off long enough that the unit fills up and drops s_tready
            if (!held_once && board.results == HOLD_AT) begin
                held_once  = 1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (board.results >= QUIET_LO && board.results < QUIET_HI) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 29);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [SAMPLE_W-1:0] limit;
        logic [SAMPLE_W-1:0] thr;
        logic [COUNT_W-1:0]  minc;
        logic [SENSOR_W-1:0] sensor;
        int                  per_phase;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: zero sample, extremes around the limit and threshold,
        // then enough samples to wrap sensor 0's ring
        send_sample(0, 0);
        send_sample(0, 511);
        send_sample(0, 1);
        send_sample(0, 299);
        send_sample(0, 300);
        send_sample(0, 149);
        send_sample(0, 150);
        send_sample(0, 100);
        send_sample(0, 2);
        // Sensor numbers beyond the last sensor leave state alone
        send_sample(5, 123);
        send_sample(15, 511);
        // Highest sensor: four close samples just exceed the default min count
        repeat (4) send_sample(4, 40);
        send_sample(1, 511);
        send_sample(2, 256);
        send_sample(3, 128);

        // Zero valid limit: nothing qualifies; a write to the unused index is dropped
        configure(0, 0, 0);
        write_reg(REG_UNUSED, 9'h1FF);
        cfg_valid <= 1'b0;
        send_sample(0, 100);

        // Min count at or beyond the ring length forces a zero mean, as does a valid limit of 1
        configure(511, 511, 8);
        send_sample(4, 40);
        configure(511, 511, 32);
        send_sample(0, 50);
        configure(1, 511, 0);
        send_sample(4, 1);

        // Random phases, first and last at fixed settings
        per_phase = RANDOM_BEATS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                limit = 511; thr = 511; minc = 0;
            end else if (p == PHASES - 1) begin
                limit = VALID_LIMIT_RST; thr = CLOSE_THR_RST; minc = MIN_COUNT_RST;
            end else begin
                limit = SAMPLE_W'($urandom_range(511, 40));
                thr   = SAMPLE_W'($urandom_range(511));
                minc  = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(32, 8))
                                                 : COUNT_W'($urandom_range(7));
            end
            configure(limit, thr, minc);
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(9) == 0)
                    sensor = SENSOR_W'($urandom_range(15, SENSORS));
                else
                    sensor = SENSOR_W'($urandom_range(SENSORS - 1));
                send_sample(sensor, pick_sample(limit));
            end
        end

        drain();
        // Catch any stray beat after the last expected one
        repeat (60) @(posedge aclk);

        $display("covered %0d samples (%0d out-of-range sensors), %0d results",
                 board.samples, board.stray_sensor, board.results);
        $display("nonzero means %0d, close flags %0d, over %0d setting phases",
                 board.means_seen, board.near_seen, PHASES + 5);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", board.pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hw/rtl/gwmp_pkg.sv
hw/rtl/gwmp_ram.sv
hw/rtl/gwmp_ctrl.sv
hw/rtl/gwmp_dp.sv
hw/rtl/gated_window_mean_proximity_unit.sv
sim/gated_window_mean_proximity_unit_test.sv
